[rtl/owm_pkg.sv]
// Shared types, codes and helpers for the one-wire bus master.
`timescale 1ns / 1ps
`default_nettype none

package owm_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_PRES_POLL = 4'd2,
        PH_PRES_END  = 4'd3,
        PH_W_OPEN    = 4'd4,
        PH_W_DATA    = 4'd5,
        PH_W_END     = 4'd6,
        PH_RST_BEGIN = 4'd7,
        PH_R_OPEN    = 4'd8,
        PH_R_REL     = 4'd9,
        PH_R_SAMPLE  = 4'd10,
        PH_FIN       = 4'd11,
        PH_DONE      = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_DONE   = 2'd1,
        ST_NODEV  = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    // Kinds of input word.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [2:0] CFG_PRESENCE_HOLD = 3'd1;
    localparam logic [2:0] CFG_SLOT_START    = 3'd2;
    localparam logic [2:0] CFG_SAMPLE_WAIT   = 3'd3;
    localparam logic [2:0] CFG_SLOT          = 3'd4;
    localparam logic [2:0] CFG_RECOVERY      = 3'd5;
    localparam logic [2:0] CFG_POLL_INTERVAL = 3'd6;
    localparam logic [2:0] CFG_POLL_COUNT    = 3'd7;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 10;

    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [9:0] presence_hold_ticks;
        logic [7:0] slot_start_ticks;
        logic [7:0] sample_wait_ticks;
        logic [7:0] slot_ticks;
        logic [7:0] recovery_ticks;
        logic [7:0] presence_poll_ticks;
        logic [7:0] presence_polls;
    } cfg_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] send_data;
        logic        read_back;
        logic        bus_level;
    } item_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        status_t     status;
        logic [15:0] recv_data;
    } res_t;

    // A zero timing value counts as a single tick.
    function automatic logic [9:0] load_delay(input logic [9:0] d);
        return (d == 10'd0) ? 10'd1 : d;
    endfunction

endpackage

`default_nettype wire

[rtl/owm_core.sv]
// Exchange sequencer: phase machine, countdown, bit and byte shifting.
`timescale 1ns / 1ps
`default_nettype none

module owm_core #(
    parameter int unsigned BUF_BYTES = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire owm_pkg::item_t item,
    input  wire owm_pkg::cfg_t  cfg,
    output owm_pkg::res_t       res
);
    import owm_pkg::*;

    localparam int unsigned BIW = $clog2(BUF_BYTES + 1);

    phase_t         phase_reg, phase_next;
    logic [9:0]     delay_count_reg, delay_count_next;
    logic [7:0]     poll_count_reg, poll_count_next;
    logic [3:0]     bit_count_reg, bit_count_next;
    logic [BIW-1:0] byte_index_reg, byte_index_next;
    logic [7:0]     shift_byte_reg, shift_byte_next;
    logic [15:0]    send_word_reg, send_word_next;
    logic [15:0]    recv_word_reg, recv_word_next;
    logic           read_back_pending_reg, read_back_pending_next;
    logic           in_read_phase_reg, in_read_phase_next;
    logic           device_present_reg, device_present_next;
    logic           line_low_reg, line_low_next;

    logic           is_start;
    logic           fire;
    logic [BIW-1:0] bi_inc;
    logic [7:0]     poll_inc;
    logic [3:0]     bit_dec;
    logic [7:0]     sample_byte;
    logic [7:0]     next_send_byte;

    assign is_start    = (item.req_type == REQ_START);
    assign fire        = !is_start && (phase_reg != PH_IDLE) && (delay_count_reg <= 10'd1);
    assign bi_inc      = byte_index_reg + BIW'(1);
    assign poll_inc    = poll_count_reg + 8'd1;
    assign bit_dec     = bit_count_reg - 4'd1;
    assign sample_byte = {item.bus_level, shift_byte_reg[7:1]};

    // Bytes past the second are sent as zero.
    always_comb
    begin
        if (bi_inc == BIW'(1))
            next_send_byte = send_word_reg[15:8];
        else
            next_send_byte = 8'd0;
    end

    always_comb
    begin
        phase_next             = phase_reg;
        delay_count_next       = delay_count_reg;
        poll_count_next        = poll_count_reg;
        bit_count_next         = bit_count_reg;
        byte_index_next        = byte_index_reg;
        shift_byte_next        = shift_byte_reg;
        send_word_next         = send_word_reg;
        recv_word_next         = recv_word_reg;
        read_back_pending_next = read_back_pending_reg;
        in_read_phase_next     = in_read_phase_reg;
        device_present_next    = device_present_reg;
        line_low_next          = line_low_reg;

        if (is_start)
        begin
            if (phase_reg == PH_IDLE)
            begin
                send_word_next         = item.send_data;
                read_back_pending_next = item.read_back;
                in_read_phase_next     = 1'b0;
                device_present_next    = 1'b0;
                recv_word_next         = 16'd0;
                poll_count_next        = 8'd0;
                bit_count_next         = 4'd8;
                byte_index_next        = '0;
                shift_byte_next        = 8'd0;
                line_low_next          = 1'b1;
                delay_count_next       = load_delay(cfg.reset_low_ticks);
                phase_next             = PH_RST_LOW;
            end
        end
        else if (phase_reg != PH_IDLE && !fire)
        begin
            delay_count_next = delay_count_reg - 10'd1;
        end
        else if (fire)
        begin
            delay_count_next = 10'd0;
            case (phase_reg)
                PH_RST_LOW:
                begin
                    line_low_next    = 1'b0;
                    delay_count_next = load_delay({2'b00, cfg.sample_wait_ticks});
                    poll_count_next  = 8'd0;
                    phase_next       = PH_PRES_POLL;
                end
                PH_PRES_POLL:
                begin
                    if (!item.bus_level)
                    begin
                        device_present_next = 1'b1;
                        delay_count_next    = load_delay(cfg.presence_hold_ticks);
                        phase_next          = PH_PRES_END;
                    end
                    else
                    begin
                        poll_count_next  = poll_inc;
                        delay_count_next = load_delay({2'b00, cfg.presence_poll_ticks});
                        if (poll_inc == 8'd0 || poll_inc >= cfg.presence_polls)
                            phase_next = PH_PRES_END;
                    end
                end
                PH_PRES_END:
                begin
                    if (!device_present_reg)
                    begin
                        line_low_next = 1'b0;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        delay_count_next = load_delay({2'b00, cfg.recovery_ticks});
                        bit_count_next   = 4'd8;
                        byte_index_next  = '0;
                        shift_byte_next  = in_read_phase_reg ? 8'd0 : send_word_reg[7:0];
                        phase_next       = in_read_phase_reg ? PH_R_OPEN : PH_W_OPEN;
                    end
                end
                PH_W_OPEN:
                begin
                    line_low_next    = 1'b1;
                    delay_count_next = load_delay({2'b00, cfg.slot_start_ticks});
                    phase_next       = PH_W_DATA;
                end
                PH_W_DATA:
                begin
                    if (shift_byte_reg[0])
                        line_low_next = 1'b0;
                    delay_count_next = load_delay({2'b00, cfg.slot_ticks});
                    phase_next       = PH_W_END;
                end
                PH_W_END:
                begin
                    line_low_next    = 1'b0;
                    delay_count_next = load_delay({2'b00, cfg.recovery_ticks});
                    if (bit_dec != 4'd0)
                    begin
                        bit_count_next  = bit_dec;
                        shift_byte_next = {1'b0, shift_byte_reg[7:1]};
                        phase_next      = PH_W_OPEN;
                    end
                    else
                    begin
                        bit_count_next  = 4'd8;
                        byte_index_next = bi_inc;
                        if (bi_inc >= BIW'(BUF_BYTES))
                        begin
                            if (read_back_pending_reg)
                            begin
                                in_read_phase_next  = 1'b1;
                                device_present_next = 1'b0;
                                phase_next          = PH_RST_BEGIN;
                            end
                            else
                            begin
                                phase_next = PH_FIN;
                            end
                        end
                        else
                        begin
                            shift_byte_next = next_send_byte;
                            phase_next      = PH_W_OPEN;
                        end
                    end
                end
                PH_RST_BEGIN:
                begin
                    line_low_next    = 1'b1;
                    delay_count_next = load_delay(cfg.reset_low_ticks);
                    phase_next       = PH_RST_LOW;
                end
                PH_R_OPEN:
                begin
                    line_low_next    = 1'b1;
                    delay_count_next = load_delay({2'b00, cfg.slot_start_ticks});
                    phase_next       = PH_R_REL;
                end
                PH_R_REL:
                begin
                    line_low_next    = 1'b0;
                    delay_count_next = load_delay({2'b00, cfg.sample_wait_ticks});
                    phase_next       = PH_R_SAMPLE;
                end
                PH_R_SAMPLE:
                begin
                    delay_count_next = load_delay({2'b00, cfg.slot_ticks});
                    phase_next       = PH_R_OPEN;
                    if (bit_dec != 4'd0)
                    begin
                        bit_count_next  = bit_dec;
                        shift_byte_next = sample_byte;
                    end
                    else
                    begin
                        bit_count_next = 4'd8;
                        // Only the first two bytes read are kept.
                        if (byte_index_reg == BIW'(0))
                            recv_word_next = {recv_word_reg[15:8], sample_byte};
                        else if (byte_index_reg == BIW'(1))
                            recv_word_next = {sample_byte, recv_word_reg[7:0]};
                        shift_byte_next = 8'd0;
                        byte_index_next = bi_inc;
                        if (bi_inc >= BIW'(BUF_BYTES))
                            phase_next = PH_FIN;
                    end
                end
                PH_FIN:
                begin
                    delay_count_next = load_delay({2'b00, cfg.recovery_ticks});
                    phase_next       = PH_DONE;
                end
                PH_DONE:
                begin
                    line_low_next = 1'b0;
                    phase_next    = PH_IDLE;
                end
                default:
                begin
                    line_low_next = 1'b0;
                    phase_next    = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        res.drive_low = line_low_next;
        res.busy_res  = (phase_next != PH_IDLE);
        res.status    = ST_NONE;
        res.recv_data = 16'd0;
        if (is_start && phase_reg != PH_IDLE)
            res.status = ST_REJECT;
        else if (fire && phase_reg == PH_PRES_END && !device_present_reg)
            res.status = ST_NODEV;
        else if (fire && phase_reg == PH_DONE)
        begin
            res.status    = ST_DONE;
            res.recv_data = recv_word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_IDLE;
            delay_count_reg       <= 10'd0;
            poll_count_reg        <= 8'd0;
            bit_count_reg         <= 4'd8;
            byte_index_reg        <= '0;
            shift_byte_reg        <= 8'd0;
            send_word_reg         <= 16'd0;
            recv_word_reg         <= 16'd0;
            read_back_pending_reg <= 1'b0;
            in_read_phase_reg     <= 1'b0;
            device_present_reg    <= 1'b0;
            line_low_reg          <= 1'b0;
        end
        else if (step)
        begin
            phase_reg             <= phase_next;
            delay_count_reg       <= delay_count_next;
            poll_count_reg        <= poll_count_next;
            bit_count_reg         <= bit_count_next;
            byte_index_reg        <= byte_index_next;
            shift_byte_reg        <= shift_byte_next;
            send_word_reg         <= send_word_next;
            recv_word_reg         <= recv_word_next;
            read_back_pending_reg <= read_back_pending_next;
            in_read_phase_reg     <= in_read_phase_next;
            device_present_reg    <= device_present_next;
            line_low_reg          <= line_low_next;
        end
    end

    // Every active phase has a countdown of at least one tick pending.
    a_delay_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |-> delay_count_reg != 10'd0)
        else $error("active phase with empty countdown");

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg != 4'd0 && bit_count_reg <= 4'd8)
        else $error("bit counter out of range");

    a_recv_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.recv_data != 16'd0 |-> res.status == ST_DONE)
        else $error("received data shown outside a done word");

    a_end_releases: assert property (@(posedge clk) disable iff (!rst_n)
        step && (res.status == ST_DONE || res.status == ST_NODEV)
        |-> !res.busy_res && !res.drive_low)
        else $error("exchange ended with line held or still busy");

endmodule

`default_nettype wire

[rtl/one_wire_bus_master.sv]
// Top level of the one-wire bus master: stream ports, config registers, pipeline.
//
//  Channel  Direction  Handshake               Contents
//  s_axis   in         s_axis_tvalid/tready    tick or start word, line sample
//  m_axis   out        m_axis_tvalid/tready    one result word per input word
//  cfg      in         cfg_we (no wait)        timing register writes
//
// Each word passes an input register and a result register; one word per cycle
// is sustained when the output is taken. The phase machine and its countdown
// update as a word moves from the input register to the result register, so
// each word sees the state left by the previous one.
// A stall on m_axis holds both registers; s_axis_tready drops only when both
// are full. Reset clears the sequence state, the valid flags and the timing
// registers (to their default timings); no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module one_wire_bus_master #(
    parameter int unsigned BUF_BYTES = 2
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] send_data, [16] read_back, [17] bus_level, [23:18] zero
    input  wire logic [23:0]                     s_axis_tdata,
    // [0] req_type
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] drive_low, [1] busy_res, [3:2] status, [19:4] recv_data, [23:20] zero
    output logic [23:0]                          m_axis_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [owm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [owm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import owm_pkg::*;

    cfg_t  cfg_reg;
    item_t in_item_reg;
    logic  in_valid_reg;
    logic  out_valid_reg;
    res_t  out_res_reg;
    res_t  core_res;
    logic  advance;
    logic  step;
    logic  s_accept;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks     <= 10'd480;
            cfg_reg.presence_hold_ticks <= 10'd480;
            cfg_reg.slot_start_ticks    <= 8'd2;
            cfg_reg.sample_wait_ticks   <= 8'd2;
            cfg_reg.slot_ticks          <= 8'd60;
            cfg_reg.recovery_ticks      <= 8'd10;
            cfg_reg.presence_poll_ticks <= 8'd10;
            cfg_reg.presence_polls      <= 8'd120;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_RESET_LOW:     cfg_reg.reset_low_ticks     <= cfg_wdata;
                CFG_PRESENCE_HOLD: cfg_reg.presence_hold_ticks <= cfg_wdata;
                CFG_SLOT_START:    cfg_reg.slot_start_ticks    <= cfg_wdata[7:0];
                CFG_SAMPLE_WAIT:   cfg_reg.sample_wait_ticks   <= cfg_wdata[7:0];
                CFG_SLOT:          cfg_reg.slot_ticks          <= cfg_wdata[7:0];
                CFG_RECOVERY:      cfg_reg.recovery_ticks      <= cfg_wdata[7:0];
                CFG_POLL_INTERVAL: cfg_reg.presence_poll_ticks <= cfg_wdata[7:0];
                CFG_POLL_COUNT:    cfg_reg.presence_polls      <= cfg_wdata[7:0];
                default:           cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= s_accept || (in_valid_reg && !advance);
            out_valid_reg <= step || (out_valid_reg && !m_axis_tready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.req_type  <= s_axis_tuser;
            in_item_reg.send_data <= s_axis_tdata[15:0];
            in_item_reg.read_back <= s_axis_tdata[16];
            in_item_reg.bus_level <= s_axis_tdata[17];
        end
        if (step)
            out_res_reg <= core_res;
    end

    owm_core #(
        .BUF_BYTES (BUF_BYTES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_res_reg.recv_data, out_res_reg.status,
                            out_res_reg.busy_res, out_res_reg.drive_low};

endmodule

`default_nettype wire

[test/one_wire_bus_master_chk.sv]
// Checker for the one-wire bus master: predicts each result word and compares it field by field.
`timescale 1ns / 1ps

module one_wire_bus_master_chk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [23:0]                     m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [owm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [owm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              errors,
    output int                              outstanding,
    output logic                            exch_active,
    output int                              words_in,
    output int                              n_done,
    output int                              n_nodev,
    output int                              n_reject
);
    import owm_pkg::*;

    localparam int BUF_BYTES = 2;

    // Timing registers as the block should hold them.
    cfg_t        timings;

    // Sequence state of the predicted master.
    phase_t      seq_phase;
    logic [9:0]  tick_count;
    logic [7:0]  polls_seen;
    logic [3:0]  bits_left;
    logic [1:0]  byte_pos;
    logic [7:0]  shifter;
    logic [15:0] tx_word;
    logic [15:0] rx_word;
    logic        want_read;
    logic        reading;
    logic        seen_device;
    logic        pull_low;

    res_t        pending_results[$];
    int          results_seen;

    // A zero timing value still waits one tick.
    function automatic logic [9:0] at_least_one(input logic [9:0] n);
        return n | {9'd0, n == 10'd0};
    endfunction

    function automatic logic [7:0] tx_byte(input logic [1:0] idx);
        if (idx >= 2'd2)
            return 8'h00;
        return tx_word[8 * idx +: 8];
    endfunction

    // The action that falls due when a countdown runs out.
    function automatic status_t run_due_action(input logic bus);
        status_t st;
        st = ST_NONE;
        case (seq_phase)
            PH_RST_LOW:
            begin
                pull_low = 1'b0;
                tick_count = at_least_one({2'b00, timings.sample_wait_ticks});
                polls_seen = 8'd0;
                seq_phase = PH_PRES_POLL;
            end
            PH_PRES_POLL:
            begin
                if (!bus)
                begin
                    seen_device = 1'b1;
                    tick_count = at_least_one(timings.presence_hold_ticks);
                    seq_phase = PH_PRES_END;
                end
                else
                begin
                    polls_seen = polls_seen + 8'd1;
                    tick_count = at_least_one({2'b00, timings.presence_poll_ticks});
                    if (polls_seen == 8'd0 || polls_seen >= timings.presence_polls)
                        seq_phase = PH_PRES_END;
                end
            end
            PH_PRES_END:
            begin
                if (!seen_device)
                begin
                    pull_low = 1'b0;
                    seq_phase = PH_IDLE;
                    tick_count = 10'd0;
                    st = ST_NODEV;
                end
                else
                begin
                    tick_count = at_least_one({2'b00, timings.recovery_ticks});
                    bits_left = 4'd8;
                    byte_pos = 2'd0;
                    shifter = reading ? 8'h00 : tx_byte(2'd0);
                    seq_phase = reading ? PH_R_OPEN : PH_W_OPEN;
                end
            end
            PH_W_OPEN:
            begin
                pull_low = 1'b1;
                tick_count = at_least_one({2'b00, timings.slot_start_ticks});
                seq_phase = PH_W_DATA;
            end
            PH_W_DATA:
            begin
                // A one is written by letting go of the line early.
                if (shifter[0])
                    pull_low = 1'b0;
                tick_count = at_least_one({2'b00, timings.slot_ticks});
                seq_phase = PH_W_END;
            end
            PH_W_END:
            begin
                pull_low = 1'b0;
                tick_count = at_least_one({2'b00, timings.recovery_ticks});
                bits_left = bits_left - 4'd1;
                if (bits_left != 4'd0)
                begin
                    shifter = shifter >> 1;
                    seq_phase = PH_W_OPEN;
                end
                else
                begin
                    bits_left = 4'd8;
                    byte_pos = byte_pos + 2'd1;
                    if (byte_pos >= BUF_BYTES)
                    begin
                        if (want_read)
                        begin
                            reading = 1'b1;
                            seen_device = 1'b0;
                            seq_phase = PH_RST_BEGIN;
                        end
                        else
                            seq_phase = PH_FIN;
                    end
                    else
                    begin
                        shifter = tx_byte(byte_pos);
                        seq_phase = PH_W_OPEN;
                    end
                end
            end
            PH_RST_BEGIN:
            begin
                pull_low = 1'b1;
                tick_count = at_least_one(timings.reset_low_ticks);
                seq_phase = PH_RST_LOW;
            end
            PH_R_OPEN:
            begin
                pull_low = 1'b1;
                tick_count = at_least_one({2'b00, timings.slot_start_ticks});
                seq_phase = PH_R_REL;
            end
            PH_R_REL:
            begin
                pull_low = 1'b0;
                tick_count = at_least_one({2'b00, timings.sample_wait_ticks});
                seq_phase = PH_R_SAMPLE;
            end
            PH_R_SAMPLE:
            begin
                bits_left = bits_left - 4'd1;
                shifter = {bus, shifter[7:1]};
                tick_count = at_least_one({2'b00, timings.slot_ticks});
                seq_phase = PH_R_OPEN;
                if (bits_left == 4'd0)
                begin
                    bits_left = 4'd8;
                    if (byte_pos < 2'd2)
                        rx_word[8 * byte_pos +: 8] = shifter;
                    shifter = 8'h00;
                    byte_pos = byte_pos + 2'd1;
                    if (byte_pos >= BUF_BYTES)
                        seq_phase = PH_FIN;
                end
            end
            PH_FIN:
            begin
                tick_count = at_least_one({2'b00, timings.recovery_ticks});
                seq_phase = PH_DONE;
            end
            PH_DONE:
            begin
                pull_low = 1'b0;
                seq_phase = PH_IDLE;
                tick_count = 10'd0;
                st = ST_DONE;
            end
            default:
            begin
                pull_low = 1'b0;
                seq_phase = PH_IDLE;
                tick_count = 10'd0;
            end
        endcase
        return st;
    endfunction

    function automatic res_t bus_master_step(input logic kind, input logic [15:0] data,
                                             input logic rb, input logic bus);
        res_t        r;
        status_t     st;
        logic [15:0] rx;
        st = ST_NONE;
        rx = 16'h0000;
        if (kind == REQ_START)
        begin
            if (seq_phase != PH_IDLE)
                st = ST_REJECT;
            else
            begin
                tx_word = data;
                want_read = rb;
                reading = 1'b0;
                seen_device = 1'b0;
                rx_word = 16'h0000;
                polls_seen = 8'd0;
                bits_left = 4'd8;
                byte_pos = 2'd0;
                shifter = 8'h00;
                pull_low = 1'b1;
                tick_count = at_least_one(timings.reset_low_ticks);
                seq_phase = PH_RST_LOW;
            end
        end
        else if (seq_phase != PH_IDLE)
        begin
            if (tick_count > 10'd1)
                tick_count = tick_count - 10'd1;
            else
            begin
                tick_count = 10'd0;
                st = run_due_action(bus);
                if (st == ST_DONE)
                    rx = rx_word;
            end
        end
        r.drive_low = pull_low;
        r.busy_res = (seq_phase != PH_IDLE);
        r.status = st;
        r.recv_data = rx;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            timings.reset_low_ticks = 10'd480;
            timings.presence_hold_ticks = 10'd480;
            timings.slot_start_ticks = 8'd2;
            timings.sample_wait_ticks = 8'd2;
            timings.slot_ticks = 8'd60;
            timings.recovery_ticks = 8'd10;
            timings.presence_poll_ticks = 8'd10;
            timings.presence_polls = 8'd120;
            seq_phase = PH_IDLE;
            tick_count = 10'd0;
            polls_seen = 8'd0;
            bits_left = 4'd8;
            byte_pos = 2'd0;
            shifter = 8'h00;
            tx_word = 16'h0000;
            rx_word = 16'h0000;
            want_read = 1'b0;
            reading = 1'b0;
            seen_device = 1'b0;
            pull_low = 1'b0;
            pending_results.delete();
            results_seen = 0;
            errors = 0;
            words_in = 0;
            n_done = 0;
            n_nodev = 0;
            n_reject = 0;
            outstanding <= 0;
            exch_active <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.drive_low = m_axis_tdata[0];
                got.busy_res = m_axis_tdata[1];
                got.status = status_t'(m_axis_tdata[3:2]);
                got.recv_data = m_axis_tdata[19:4];
                if (pending_results.size() == 0)
                begin
                    if (errors < 10)
                        $display("Result word %0d arrived with nothing expected: %h",
                                 results_seen, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want != got)
                    begin
                        // Fields shown as drive_low/busy/status/data.
                        if (errors < 10)
                            $display("Word %0d: expected %0b/%0b/%0d/%h, got %0b/%0b/%0d/%h",
                                     results_seen,
                                     want.drive_low, want.busy_res, want.status,
                                     want.recv_data,
                                     got.drive_low, got.busy_res, got.status,
                                     got.recv_data);
                        errors++;
                    end
                end
                results_seen++;
            end

            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_RESET_LOW:     timings.reset_low_ticks = cfg_wdata;
                    CFG_PRESENCE_HOLD: timings.presence_hold_ticks = cfg_wdata;
                    CFG_SLOT_START:    timings.slot_start_ticks = cfg_wdata[7:0];
                    CFG_SAMPLE_WAIT:   timings.sample_wait_ticks = cfg_wdata[7:0];
                    CFG_SLOT:          timings.slot_ticks = cfg_wdata[7:0];
                    CFG_RECOVERY:      timings.recovery_ticks = cfg_wdata[7:0];
                    CFG_POLL_INTERVAL: timings.presence_poll_ticks = cfg_wdata[7:0];
                    CFG_POLL_COUNT:    timings.presence_polls = cfg_wdata[7:0];
                    default:           ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                want = bus_master_step(s_axis_tuser, s_axis_tdata[15:0],
                                       s_axis_tdata[16], s_axis_tdata[17]);
                pending_results.push_back(want);
                words_in++;
                case (want.status)
                    ST_DONE:   n_done++;
                    ST_NODEV:  n_nodev++;
                    ST_REJECT: n_reject++;
                    default:   ;
                endcase
            end

            outstanding <= pending_results.size();
            exch_active <= (seq_phase != PH_IDLE);
        end
    end

endmodule

[test/tb_one_wire_bus_master.sv]
// Testbench top for the one-wire bus master: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_one_wire_bus_master;
    import owm_pkg::*;

    // How the simulated device answers on the line.
    typedef enum int
    {
        DEV_PRESENT,
        DEV_ABSENT,
        DEV_FLAKY,
        DEV_LEAVES
    } device_t;

    localparam int RANDOM_WORDS = 200;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [15:0] send_data, [16] read_back, [17] bus_level, [23:18] zero
    logic [23:0]           s_axis_tdata;
    // [0] req_type
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [0] drive_low, [1] busy_res, [3:2] status, [19:4] recv_data, [23:20] zero
    logic [23:0]           m_axis_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int                    errors;
    int                    outstanding;
    logic                  exch_active;
    int                    words_in;
    int                    n_done;
    int                    n_nodev;
    int                    n_reject;

    device_t               dev_mode = DEV_PRESENT;
    int                    ticks_since_start = 0;
    int                    send_stretch = 0;
    int                    recv_stretch = 0;
    bit                    send_calm = 1'b0;
    bit                    recv_calm = 1'b0;
    int                    settings_used = 1;
    int                    random_words = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    one_wire_bus_master u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    one_wire_bus_master_chk u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .errors        (errors),
        .outstanding   (outstanding),
        .exch_active   (exch_active),
        .words_in      (words_in),
        .n_done        (n_done),
        .n_nodev       (n_nodev),
        .n_reject      (n_reject)
    );

    // Sender gaps: calm stretches with none, otherwise mostly short and now and then long.
    function automatic int next_gap();
        int r;
        if (send_stretch == 0)
        begin
            send_calm = ($urandom_range(0, 3) == 0);
            send_stretch = $urandom_range(40, 200);
        end
        send_stretch--;
        if (send_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int next_stall();
        int r;
        if (recv_stretch == 0)
        begin
            recv_calm = ($urandom_range(0, 3) == 0);
            recv_stretch = $urandom_range(50, 300);
        end
        recv_stretch--;
        if (recv_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        if (r < 99)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic line_level();
        case (dev_mode)
            DEV_ABSENT: return 1'b1;
            DEV_FLAKY:  return ($urandom_range(0, 6) != 0);
            DEV_LEAVES: return (ticks_since_start >= 20);
            default:    return 1'(($urandom_range(0, 1)));
        endcase
    endfunction

    function automatic device_t pick_device();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return DEV_PRESENT;
        if (r < 8)
            return DEV_ABSENT;
        if (r < 9)
            return DEV_FLAKY;
        return DEV_LEAVES;
    endfunction

    // Mostly very short timings so that many exchanges complete.
    function automatic logic [9:0] short_ticks(input int top);
        if ($urandom_range(0, 7) == 0)
            return 10'($urandom_range(0, top));
        return 10'($urandom_range(0, 2));
    endfunction

    function automatic cfg_t pick_timings();
        cfg_t t;
        t.reset_low_ticks = short_ticks(20);
        t.presence_hold_ticks = short_ticks(20);
        t.slot_start_ticks = 8'(short_ticks(8));
        t.sample_wait_ticks = 8'(short_ticks(8));
        t.slot_ticks = 8'(short_ticks(8));
        t.recovery_ticks = 8'(short_ticks(8));
        t.presence_poll_ticks = 8'(short_ticks(8));
        t.presence_polls = 8'($urandom_range(0, 4));
        return t;
    endfunction

    function automatic cfg_t uniform_timings(input logic [9:0] v);
        cfg_t t;
        t.reset_low_ticks = v;
        t.presence_hold_ticks = v;
        t.slot_start_ticks = v[7:0];
        t.sample_wait_ticks = v[7:0];
        t.slot_ticks = v[7:0];
        t.recovery_ticks = v[7:0];
        t.presence_poll_ticks = v[7:0];
        t.presence_polls = v[7:0];
        return t;
    endfunction

    task automatic push_word(input logic kind, input logic [15:0] data, input logic rb,
                             input logic bus);
        int n;
        n = next_gap();
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {6'd0, bus, rb, data};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic push_tick(input logic bus);
        push_word(REQ_TICK, 16'($urandom), 1'($urandom), bus);
        ticks_since_start++;
    endtask

    task automatic send_start(input logic [15:0] data, input logic rb, input device_t mode);
        dev_mode = mode;
        ticks_since_start = 0;
        push_word(REQ_START, data, rb, 1'($urandom));
    endtask

    // Holds the sender off until every word sent so far has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Keeps ticking until the exchange under way has ended, then lets the pipeline settle.
    task automatic finish_exchange();
        drain();
        while (exch_active)
        begin
            repeat (16) push_tick(line_level());
            drain();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge clk);
    endtask

    // The unused top bits of the narrow registers get random values.
    task automatic apply_timings(input cfg_t t);
        logic [1:0] hi;
        put_reg(CFG_RESET_LOW, t.reset_low_ticks);
        put_reg(CFG_PRESENCE_HOLD, t.presence_hold_ticks);
        hi = 2'($urandom);
        put_reg(CFG_SLOT_START, {hi, t.slot_start_ticks});
        hi = 2'($urandom);
        put_reg(CFG_SAMPLE_WAIT, {hi, t.sample_wait_ticks});
        hi = 2'($urandom);
        put_reg(CFG_SLOT, {hi, t.slot_ticks});
        hi = 2'($urandom);
        put_reg(CFG_RECOVERY, {hi, t.recovery_ticks});
        hi = 2'($urandom);
        put_reg(CFG_POLL_INTERVAL, {hi, t.presence_poll_ticks});
        hi = 2'($urandom);
        put_reg(CFG_POLL_COUNT, {hi, t.presence_polls});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_word();
        if ($urandom_range(0, exch_active ? 59 : 3) == 0)
            send_start(16'($urandom), 1'($urandom), pick_device());
        else
            push_tick(line_level());
        random_words++;
        if ($urandom_range(0, 149) == 0)
            drain();
    endtask

    initial
    begin : receiver
        int hold;
        hold = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = next_stall();
            end
        end
    end

    initial
    begin : watchdog
        #40_000_000;
        $display("Run timed out with %0d result words outstanding", outstanding);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        s_axis_tvalid <= 1'b0;
        s_axis_tuser <= REQ_TICK;
        s_axis_tdata <= 24'd0;
        cfg_we <= 1'b0;
        cfg_addr <= CFG_RESET_LOW;
        cfg_wdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timings: ticks while idle, then an exchange with starts refused while busy.
        // The default reset pulse runs out in full; the rest of the exchange uses the
        // shortest timings, written while the pulse is still under way.
        push_tick(1'b0);
        push_tick(1'b1);
        send_start(16'hA55A, 1'b1, DEV_PRESENT);
        send_start(16'hFFFF, 1'b1, DEV_PRESENT);
        push_tick(line_level());
        send_start(16'h0000, 1'b0, DEV_PRESENT);
        drain();
        apply_timings(uniform_timings(10'd1));
        finish_exchange();

        // Shortest timings: all ones sent, no device, and a device that is gone by the
        // second presence check.
        send_start(16'hFFFF, 1'b0, DEV_PRESENT);
        finish_exchange();
        send_start(16'h1234, 1'b1, DEV_ABSENT);
        finish_exchange();
        send_start(16'h5AA5, 1'b1, DEV_LEAVES);
        finish_exchange();

        // All registers zero: every wait counts as one tick and one failed poll gives up.
        apply_timings(uniform_timings(10'd0));
        send_start(16'h8001, 1'b1, DEV_PRESENT);
        finish_exchange();
        send_start(16'h7FFE, 1'b0, DEV_ABSENT);
        finish_exchange();

        while (random_words < RANDOM_WORDS)
        begin
            apply_timings(pick_timings());
            repeat (100) random_word();
            finish_exchange();
        end

        $display("Run covered %0d input words under %0d timing settings.",
                 words_in, settings_used);
        $display("Exchanges: %0d completed, %0d without a device, %0d starts refused.",
                 n_done, n_nodev, n_reject);
        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
